### design/msort_pkg.sv
`default_nettype none

package msort_pkg;

   localparam int DATA_W = 32;

   typedef struct packed {
      logic signed [DATA_W-1:0] data_value;
      logic                     is_last;
   } msort_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     last_out;
      logic                     overflow;
   } msort_rsp_type;

endpackage

`default_nettype wire

### design/msort_ram.sv
`default_nettype none

// simple dual-port RAM, one write port, one registered read port
module msort_ram #(
   parameter int WIDTH = msort_pkg::DATA_W,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/merge_sorter_core.sv
`default_nettype none

// merge_sorter_core
// Collects a set of signed 32-bit values and returns them in ascending order.
// Input channel: a transaction is taken on a rising edge with start high and
// busy low. Each transaction stores one value; is_last ends the set. At most
// SET_SIZE values are kept; later ones are dropped and every result of that
// run then carries overflow.
// Loading takes one value per cycle. After the last value a bottom-up merge
// sort runs over two RAMs in ping-pong: ceil(log2(n)) passes through the single
// shared comparator, each pass setting up and merging its run pairs in turn.
// Then S_PASS starts the output, S_OUT reads the values out (each result
// appears in the cycle after its read) and S_FIN closes the run; busy stays
// high until the run is closed.
// Result channel: rsp_strobe marks a transaction valid for exactly one cycle;
// the receiver cannot stall, so no backpressure exists. last_out marks the
// final value of the run.
// Reset (synchronous, active high) returns to the loading state with an
// empty set; RAM contents are not cleared since only written entries are used.
module merge_sorter_core #(
   parameter int SET_SIZE = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire msort_pkg::msort_req_type req_payload,
   output logic                         rsp_strobe,
   output msort_pkg::msort_rsp_type     rsp_payload
);

   localparam int AW = $clog2(SET_SIZE);        // RAM address
   localparam int CW = $clog2(SET_SIZE + 1);    // count, holds SET_SIZE itself
   localparam int PW = $clog2(SET_SIZE) + 2;    // run bounds, hold up to 4*SET_SIZE-1
   localparam int DW = msort_pkg::DATA_W;

   localparam logic [2:0] S_IDLE  = 3'd0;   // loading values
   localparam logic [2:0] S_PASS  = 3'd1;   // start of a merge pass
   localparam logic [2:0] S_PAIR  = 3'd2;   // set up the next run pair
   localparam logic [2:0] S_HEADA = 3'd3;   // head of run A arrives
   localparam logic [2:0] S_MERGE = 3'd4;   // one output element per cycle
   localparam logic [2:0] S_OUT   = 3'd5;   // stream sorted values
   localparam logic [2:0] S_FIN   = 3'd6;   // last result on the port

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          dropped_ff, dropped_in;
   logic          src_sel_ff, src_sel_in;   // 0: sorted data lives in RAM 0
   logic [PW-1:0] width_ff, width_in;
   logic [PW-1:0] lo_ff, lo_in;
   logic [PW-1:0] ia_ff, ia_in, ea_ff, ea_in;
   logic [PW-1:0] ib_ff, ib_in, eb_ff, eb_in;
   logic [PW-1:0] od_ff, od_in;
   logic [DW-1:0] head_a_ff, head_a_in, head_b_ff, head_b_in;
   logic          refill_a_ff, refill_a_in, refill_b_ff, refill_b_in;
   logic [CW-1:0] k_ff, k_in;
   logic          emit_ff, emit_in, emit_last_ff, emit_last_in;

   logic [PW-1:0] cnt_pw, ea_sum, eb_sum, ea_lim, eb_lim, ia_nx, ib_nx;
   logic [CW-1:0] k_nx;
   logic          a_done, b_done, a_lt_b, take_b, accept;
   logic [DW-1:0] eff_a, eff_b, win, src_rd;

   logic          ram0_wr_en, ram1_wr_en;
   logic [AW-1:0] ram0_wr_addr, ram1_wr_addr, rd_addr;
   logic [DW-1:0] ram0_wr_data, ram0_rd_data, ram1_rd_data;

   msort_ram #(.WIDTH(DW), .DEPTH(SET_SIZE)) u_ram0 (
      .clock   (clock),
      .wr_en   (ram0_wr_en),
      .wr_addr (ram0_wr_addr),
      .wr_data (ram0_wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram0_rd_data)
   );

   msort_ram #(.WIDTH(DW), .DEPTH(SET_SIZE)) u_ram1 (
      .clock   (clock),
      .wr_en   (ram1_wr_en),
      .wr_addr (ram1_wr_addr),
      .wr_data (win),
      .rd_addr (rd_addr),
      .rd_data (ram1_rd_data)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign src_rd = src_sel_ff ? ram1_rd_data : ram0_rd_data;
   assign cnt_pw = {{(PW-CW){1'b0}}, count_ff};

   // run bounds for the pair starting at lo, clipped to the set size
   assign ea_sum = lo_ff + width_ff;
   assign eb_sum = lo_ff + (width_ff << 1);
   assign ea_lim = (ea_sum < cnt_pw) ? ea_sum : cnt_pw;
   assign eb_lim = (eb_sum < cnt_pw) ? eb_sum : cnt_pw;

   // shared compare unit; a freshly read head comes straight from the RAM
   assign eff_a  = refill_a_ff ? src_rd : head_a_ff;
   assign eff_b  = refill_b_ff ? src_rd : head_b_ff;
   assign a_done = (ia_ff == ea_ff);
   assign b_done = (ib_ff == eb_ff);
   assign a_lt_b = $signed(eff_a) < $signed(eff_b);
   assign take_b = a_done || (!b_done && !a_lt_b);   // ties go to run B
   assign win    = take_b ? eff_b : eff_a;
   assign ia_nx  = ia_ff + 1'b1;
   assign ib_nx  = ib_ff + 1'b1;
   assign k_nx   = k_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      src_sel_in   = src_sel_ff;
      width_in     = width_ff;
      lo_in        = lo_ff;
      ia_in        = ia_ff;
      ea_in        = ea_ff;
      ib_in        = ib_ff;
      eb_in        = eb_ff;
      od_in        = od_ff;
      head_a_in    = head_a_ff;
      head_b_in    = head_b_ff;
      refill_a_in  = refill_a_ff;
      refill_b_in  = refill_b_ff;
      k_in         = k_ff;
      emit_in      = 1'b0;
      emit_last_in = 1'b0;
      rd_addr      = '0;
      ram0_wr_en   = 1'b0;
      ram0_wr_addr = od_ff[AW-1:0];
      ram0_wr_data = win;
      ram1_wr_en   = 1'b0;
      ram1_wr_addr = od_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (count_ff < CW'(SET_SIZE)) begin
                  ram0_wr_en   = 1'b1;
                  ram0_wr_addr = count_ff[AW-1:0];
                  ram0_wr_data = req_payload.data_value;
                  count_in     = count_ff + 1'b1;
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_payload.is_last) begin
                  src_sel_in = 1'b0;
                  width_in   = PW'(1);
                  state_in   = S_PASS;
               end
            end
         end
         S_PASS: begin
            if (width_ff >= cnt_pw) begin
               k_in     = '0;
               state_in = S_OUT;
            end else begin
               lo_in    = '0;
               state_in = S_PAIR;
            end
         end
         S_PAIR: begin
            if (lo_ff >= cnt_pw) begin
               width_in   = width_ff << 1;
               src_sel_in = !src_sel_ff;
               state_in   = S_PASS;
            end else begin
               ia_in    = lo_ff;
               ea_in    = ea_lim;
               ib_in    = ea_lim;
               eb_in    = eb_lim;
               od_in    = lo_ff;
               rd_addr  = lo_ff[AW-1:0];
               state_in = S_HEADA;
            end
         end
         S_HEADA: begin
            head_a_in   = src_rd;
            refill_a_in = 1'b0;
            refill_b_in = 1'b1;
            rd_addr     = ib_ff[AW-1:0];
            state_in    = S_MERGE;
         end
         S_MERGE: begin
            ram0_wr_en  = src_sel_ff;
            ram1_wr_en  = !src_sel_ff;
            head_a_in   = eff_a;
            head_b_in   = eff_b;
            refill_a_in = !take_b;
            refill_b_in = take_b;
            if (take_b) begin
               ib_in   = ib_nx;
               rd_addr = ib_nx[AW-1:0];
            end else begin
               ia_in   = ia_nx;
               rd_addr = ia_nx[AW-1:0];
            end
            od_in = od_ff + 1'b1;
            if (od_ff + 1'b1 == eb_ff) begin
               lo_in    = eb_ff;
               state_in = S_PAIR;
            end
         end
         S_OUT: begin
            rd_addr      = k_ff[AW-1:0];
            emit_in      = 1'b1;
            emit_last_in = (k_nx == count_ff);
            k_in         = k_nx;
            if (k_nx == count_ff) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            count_in   = '0;
            dropped_in = 1'b0;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         emit_ff      <= 1'b0;
         emit_last_ff <= 1'b0;
         src_sel_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         emit_ff      <= emit_in;
         emit_last_ff <= emit_last_in;
         src_sel_ff   <= src_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff    <= width_in;
      lo_ff       <= lo_in;
      ia_ff       <= ia_in;
      ea_ff       <= ea_in;
      ib_ff       <= ib_in;
      eb_ff       <= eb_in;
      od_ff       <= od_in;
      head_a_ff   <= head_a_in;
      head_b_ff   <= head_b_in;
      refill_a_ff <= refill_a_in;
      refill_b_ff <= refill_b_in;
      k_ff        <= k_in;
   end

   // result transaction: data straight from the RAM read register
   assign rsp_strobe = emit_ff;
   always_comb begin
      rsp_payload.sorted_value = src_rd;
      rsp_payload.last_out     = emit_last_ff;
      rsp_payload.overflow     = dropped_ff;
   end

   a_strobe_in_output: assert property (@(posedge clock) disable iff (reset)
      emit_ff |-> (state_ff == S_OUT || state_ff == S_FIN))
      else $error("result strobe outside output phase");

   a_merge_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MERGE) |-> (ia_ff <= ea_ff && ib_ff <= eb_ff && !(a_done && b_done)))
      else $error("merge pointer past run end");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SET_SIZE))
      else $error("load count above set size");

   a_last_then_idle: assert property (@(posedge clock) disable iff (reset)
      (emit_ff && emit_last_ff) |=> (state_ff == S_IDLE && count_ff == '0 && !dropped_ff))
      else $error("run not closed after final result");

endmodule

`default_nettype wire
